// ===== hdl/windowed_pid_heater_control_defines.svh =====
// ---------------------------------------------------------------------------
// Windowed PID heater control: assertion macros
// Shared property macros for the checker. They assume clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef WINDOWED_PID_HEATER_CONTROL_DEFINES_SVH
`define WINDOWED_PID_HEATER_CONTROL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WHC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("windowed_pid_heater_control: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("windowed_pid_heater_control: next-cycle check failed");

`endif

// ===== hdl/whc_pkg.sv =====
// ---------------------------------------------------------------------------
// Windowed PID heater control: package
// Field widths, register codes, reset values and shared control types.
// ---------------------------------------------------------------------------
package whc_pkg;

  // Field widths.
  localparam int TEMP_W     = 13;
  localparam int ERR_W      = 14;
  localparam int DERIV_W    = 15;
  localparam int GAIN_W     = 16;
  localparam int WLEN_W     = 5;
  localparam int RAW_W      = 16;
  localparam int DRIVE_W    = 8;
  localparam int FRAC_SHIFT = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Default depth of the error window.
  localparam int WINDOW_DEPTH_DEF = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAD_TEMP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd5;

  // Register reset values.
  localparam logic signed [TEMP_W-1:0] TARGET_TEMP_RST   = 13'sd592;
  localparam logic signed [TEMP_W-1:0] MAX_PAD_TEMP_RST  = 13'sd672;
  localparam logic signed [GAIN_W-1:0] P_GAIN_RST        = 16'sd256;
  localparam logic signed [GAIN_W-1:0] I_GAIN_RST        = 16'sd0;
  localparam logic signed [GAIN_W-1:0] D_GAIN_RST        = 16'sd0;
  localparam logic [WLEN_W-1:0]        WINDOW_LENGTH_RST = 5'd10;

  // Output drive limit.
  localparam logic [DRIVE_W-1:0] DRIVE_MAX = 8'd255;

  // Control of the error window chain.
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

  // Load enables of the two arithmetic stages.
  typedef struct packed {
    logic ld_prod;
    logic ld_out;
  } mac_ctl_t;

endpackage

// ===== hdl/whc_cell.sv =====
// ---------------------------------------------------------------------------
// Windowed PID heater control: window cell
// One entry of the error history. It takes its neighbor's value on a shift
// and returns to zero on a clear.
// ---------------------------------------------------------------------------
module whc_cell
  import whc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  win_ctl_t                ctl,
  input  logic signed [ERR_W-1:0] d_in,
  output logic signed [ERR_W-1:0] q
);

  logic signed [ERR_W-1:0] q_r;
  logic signed [ERR_W-1:0] q_nxt;

  // Clear wins over shift when both come together.
  always_comb begin
    q_nxt = q_r;
    if (ctl.clear) begin
      q_nxt = '0;
    end else if (ctl.shift) begin
      q_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ===== hdl/whc_window.sv =====
// ---------------------------------------------------------------------------
// Windowed PID heater control: error window
// A row of cells holding the most recent errors, newest first, and the
// running sum of the live window. The entry that leaves the window is the
// one at the tap set by the window length.
// ---------------------------------------------------------------------------
module whc_window
  import whc_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int SUM_W        = ERR_W + $clog2(WINDOW_DEPTH)
)
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  win_ctl_t                ctl,
  input  logic [WLEN_W-1:0]       wlen,
  input  logic signed [ERR_W-1:0] err,
  output logic signed [SUM_W-1:0] sum_new
);

  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  logic signed [ERR_W-1:0] cell_q [WINDOW_DEPTH];
  logic [IDX_W-1:0]        tap;
  logic signed [ERR_W-1:0] drop;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;

  // Row of cells; the first takes the new error.
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      whc_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .d_in  (err),
        .q     (cell_q[i])
      );
    end else begin : g_body
      whc_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .d_in  (cell_q[i-1]),
        .q     (cell_q[i])
      );
    end
  end

  // Live length is the register held to 1..WINDOW_DEPTH; the tap is its last entry.
  always_comb begin
    if (wlen == '0) begin
      tap = '0;
    end else if (int'(wlen) > WINDOW_DEPTH) begin
      tap = IDX_W'(WINDOW_DEPTH - 1);
    end else begin
      tap = IDX_W'(wlen - WLEN_W'(1));
    end
  end

  assign drop = cell_q[tap];

  // Running sum: the leaving entry out, the new error in.
  assign sum_new = sum_r - SUM_W'(drop) + SUM_W'(err);

  always_comb begin
    sum_nxt = sum_r;
    if (ctl.clear) begin
      sum_nxt = '0;
    end else if (ctl.shift) begin
      sum_nxt = sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

endmodule

// ===== hdl/whc_mac.sv =====
// ---------------------------------------------------------------------------
// Windowed PID heater control: gain stages
// Three gain products in one registered stage, then their sum, the scale
// shift, saturation, clamping and the pad cutoff into the output register.
// ---------------------------------------------------------------------------
module whc_mac
  import whc_pkg::*;
#(
  parameter int SUM_W = ERR_W + $clog2(WINDOW_DEPTH_DEF)
)
(
  input  logic                      clk,
  input  mac_ctl_t                  ctl,
  input  logic signed [GAIN_W-1:0]  p_gain,
  input  logic signed [GAIN_W-1:0]  i_gain,
  input  logic signed [GAIN_W-1:0]  d_gain,
  input  logic signed [ERR_W-1:0]   err,
  input  logic signed [SUM_W-1:0]   sum,
  input  logic signed [DERIV_W-1:0] deriv,
  input  logic                      cutoff_in,
  output logic [DRIVE_W-1:0]        drive,
  output logic signed [RAW_W-1:0]   raw_drive,
  output logic                      cutoff,
  output logic                      clamped
);

  localparam int MUL_W = (SUM_W > DERIV_W) ? SUM_W : DERIV_W;
  localparam int ACC_W = GAIN_W + MUL_W + 2;
  localparam int SH_W  = ACC_W - FRAC_SHIFT;
  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(32767);
  localparam logic signed [SH_W-1:0] SAT_LO = -SH_W'(32768);

  logic signed [GAIN_W+ERR_W-1:0]   p_prod_r;
  logic signed [GAIN_W+SUM_W-1:0]   i_prod_r;
  logic signed [GAIN_W+DERIV_W-1:0] d_prod_r;
  logic                             cut_r;

  logic signed [ACC_W-1:0]   acc;
  logic signed [SH_W-1:0]    shifted;
  logic signed [RAW_W-1:0]   raw_sat;
  logic                      clamp_c;
  logic [DRIVE_W-1:0]        drive_c;

  logic [DRIVE_W-1:0]        drive_r;
  logic signed [RAW_W-1:0]   raw_r;
  logic                      cut_out_r;
  logic                      clamp_r;

  // Product stage.
  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      p_prod_r <= (GAIN_W+ERR_W)'(p_gain) * (GAIN_W+ERR_W)'(err);
      i_prod_r <= (GAIN_W+SUM_W)'(i_gain) * (GAIN_W+SUM_W)'(sum);
      d_prod_r <= (GAIN_W+DERIV_W)'(d_gain) * (GAIN_W+DERIV_W)'(deriv);
      cut_r    <= cutoff_in;
    end
  end

  // Sum of products, floor shift and saturation to the raw drive range.
  assign acc     = ACC_W'(p_prod_r) + ACC_W'(i_prod_r) + ACC_W'(d_prod_r);
  assign shifted = SH_W'(acc >>> FRAC_SHIFT);

  always_comb begin
    if (shifted > SAT_HI) begin
      raw_sat = RAW_W'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      raw_sat = RAW_W'(SAT_LO);
    end else begin
      raw_sat = RAW_W'(shifted);
    end
  end

  // Clamp to the duty range; the cutoff forces zero drive.
  always_comb begin
    clamp_c = 1'b0;
    drive_c = raw_sat[DRIVE_W-1:0];
    if (raw_sat[RAW_W-1]) begin
      clamp_c = 1'b1;
      drive_c = '0;
    end else if (raw_sat[RAW_W-2:DRIVE_W] != '0) begin
      clamp_c = 1'b1;
      drive_c = DRIVE_MAX;
    end
    if (cut_r) begin
      drive_c = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      drive_r   <= drive_c;
      raw_r     <= raw_sat;
      cut_out_r <= cut_r;
      clamp_r   <= clamp_c;
    end
  end

  assign drive     = drive_r;
  assign raw_drive = raw_r;
  assign cutoff    = cut_out_r;
  assign clamped   = clamp_r;

endmodule

// ===== hdl/windowed_pid_heater_control.sv =====
// ---------------------------------------------------------------------------
// Windowed PID heater control
// PID drive from a temperature reading with a sliding-window integral, a
// clamp to the PWM duty range and a pad over-temperature cutoff.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_measured_temp, in_pad_temp
//   out      output     out_valid/out_stall out_drive, out_raw_drive,
//                                           out_cutoff, out_clamped
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One beat is accepted per cycle unless all stages are full and the output stalls;
// a result passes stage one, the product and the output register. The window
// shifts once per accepted beat; the gain products take one stage, the sum the
// next. Each stage holds its beat while the next stage is full and cannot move
// on, so a stalled output blocks the input only once all three stages are full.
// Reset is synchronous; it clears the window, the running sum, the last error and
// the valid bits and sets the config registers to defaults. cfg_ready is always high.
//
module windowed_pid_heater_control
  import whc_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  // Input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [TEMP_W-1:0] in_measured_temp,
  input  logic signed [TEMP_W-1:0] in_pad_temp,
  // Result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DRIVE_W-1:0]       out_drive,
  output logic signed [RAW_W-1:0]  out_raw_drive,
  output logic                     out_cutoff,
  output logic                     out_clamped,
  // Configuration channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int SUM_W = ERR_W + $clog2(WINDOW_DEPTH);

  // Configuration registers.
  logic signed [TEMP_W-1:0] target_temp_r,   target_temp_nxt;
  logic signed [TEMP_W-1:0] max_pad_temp_r,  max_pad_temp_nxt;
  logic signed [GAIN_W-1:0] p_gain_r,        p_gain_nxt;
  logic signed [GAIN_W-1:0] i_gain_r,        i_gain_nxt;
  logic signed [GAIN_W-1:0] d_gain_r,        d_gain_nxt;
  logic [WLEN_W-1:0]        window_length_r, window_length_nxt;
  logic                     cfg_we;
  logic                     wlen_write;

  // Front stage.
  logic                      in_accept;
  logic signed [ERR_W-1:0]   err;
  logic signed [DERIV_W-1:0] deriv;
  logic                      cut;
  logic signed [ERR_W-1:0]   last_err_r, last_err_nxt;
  logic signed [SUM_W-1:0]   sum_new;
  win_ctl_t                  win_ctl;

  // Stage one payload and the valid bits of all stages.
  logic signed [ERR_W-1:0]   err1_r;
  logic signed [DERIV_W-1:0] deriv1_r;
  logic signed [SUM_W-1:0]   sum1_r;
  logic                      cut1_r;
  logic                      v1_r, v1_nxt;
  logic                      v2_r, v2_nxt;
  logic                      v3_r, v3_nxt;
  logic                      rdy1, rdy2, rdy3;
  mac_ctl_t                  mac_ctl;

  // Configuration writes.
  assign cfg_ready  = 1'b1;
  assign cfg_we     = cfg_valid & cfg_ready;
  assign wlen_write = cfg_we && (cfg_index == REG_WINDOW_LENGTH);

  always_comb begin
    target_temp_nxt   = target_temp_r;
    max_pad_temp_nxt  = max_pad_temp_r;
    p_gain_nxt        = p_gain_r;
    i_gain_nxt        = i_gain_r;
    d_gain_nxt        = d_gain_r;
    window_length_nxt = window_length_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_TEMP:   target_temp_nxt   = cfg_data[TEMP_W-1:0];
        REG_MAX_PAD_TEMP:  max_pad_temp_nxt  = cfg_data[TEMP_W-1:0];
        REG_P_GAIN:        p_gain_nxt        = cfg_data[GAIN_W-1:0];
        REG_I_GAIN:        i_gain_nxt        = cfg_data[GAIN_W-1:0];
        REG_D_GAIN:        d_gain_nxt        = cfg_data[GAIN_W-1:0];
        REG_WINDOW_LENGTH: window_length_nxt = cfg_data[WLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_temp_r   <= TARGET_TEMP_RST;
      max_pad_temp_r  <= MAX_PAD_TEMP_RST;
      p_gain_r        <= P_GAIN_RST;
      i_gain_r        <= I_GAIN_RST;
      d_gain_r        <= D_GAIN_RST;
      window_length_r <= WINDOW_LENGTH_RST;
    end else begin
      target_temp_r   <= target_temp_nxt;
      max_pad_temp_r  <= max_pad_temp_nxt;
      p_gain_r        <= p_gain_nxt;
      i_gain_r        <= i_gain_nxt;
      d_gain_r        <= d_gain_nxt;
      window_length_r <= window_length_nxt;
    end
  end

  // Stage handshake: a stage loads when it is empty or the next one moves.
  assign rdy3      = !v3_r || !out_stall;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_stall  = !rdy1;
  assign in_accept = in_valid && rdy1;

  assign v1_nxt = rdy1 ? in_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r     : v2_r;
  assign v3_nxt = rdy3 ? v2_r     : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // Error, derivative and the pad limit test of the incoming beat.
  assign err   = ERR_W'(target_temp_r) - ERR_W'(in_measured_temp);
  assign deriv = DERIV_W'(err) - DERIV_W'(last_err_r);
  assign cut   = in_pad_temp > max_pad_temp_r;

  assign last_err_nxt = in_accept ? err : last_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
    end else begin
      last_err_r <= last_err_nxt;
    end
  end

  // Error window and running sum.
  assign win_ctl.shift = in_accept;
  assign win_ctl.clear = wlen_write;

  whc_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SUM_W        (SUM_W)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (win_ctl),
    .wlen    (window_length_r),
    .err     (err),
    .sum_new (sum_new)
  );

  // Stage one register.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      err1_r   <= err;
      deriv1_r <= deriv;
      sum1_r   <= sum_new;
      cut1_r   <= cut;
    end
  end

  // Products, sum and output register.
  assign mac_ctl.ld_prod = rdy2;
  assign mac_ctl.ld_out  = rdy3;

  whc_mac #(
    .SUM_W (SUM_W)
  ) u_mac (
    .clk       (clk),
    .ctl       (mac_ctl),
    .p_gain    (p_gain_r),
    .i_gain    (i_gain_r),
    .d_gain    (d_gain_r),
    .err       (err1_r),
    .sum       (sum1_r),
    .deriv     (deriv1_r),
    .cutoff_in (cut1_r),
    .drive     (out_drive),
    .raw_drive (out_raw_drive),
    .cutoff    (out_cutoff),
    .clamped   (out_clamped)
  );

  assign out_valid = v3_r;

endmodule

// ===== hdl/whc_checker.sv =====
// ---------------------------------------------------------------------------
// Windowed PID heater control: port checker
// Checks the relation of the result fields and the output handshake.
// ---------------------------------------------------------------------------
`include "windowed_pid_heater_control_defines.svh"

module whc_checker
  import whc_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [DRIVE_W-1:0]      out_drive,
  input logic signed [RAW_W-1:0] out_raw_drive,
  input logic                    out_cutoff,
  input logic                    out_clamped
);

  // A cut-off beat never drives the heater.
  `WHC_ASSERT_NOW(a_cutoff_zero, out_valid && out_cutoff, out_drive == '0)

  // Inside the duty range the drive is the raw value itself.
  `WHC_ASSERT_NOW(a_pass_through, out_valid && !out_cutoff && !out_clamped,
                  (out_raw_drive[RAW_W-1:DRIVE_W] == '0) && (out_drive == out_raw_drive[DRIVE_W-1:0]))

  // A positive value above the range drives full duty.
  `WHC_ASSERT_NOW(a_clamp_high, out_valid && !out_cutoff && out_clamped && !out_raw_drive[RAW_W-1],
                  out_drive == DRIVE_MAX)

  // A stalled result beat stays in place.
  `WHC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_drive) && $stable(out_raw_drive))

endmodule

bind windowed_pid_heater_control whc_checker u_whc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_drive     (out_drive),
  .out_raw_drive (out_raw_drive),
  .out_cutoff    (out_cutoff),
  .out_clamped   (out_clamped)
);

// ===== dv/tb_windowed_pid_heater_control.sv =====
// ---------------------------------------------------------------------------
// Windowed PID heater control: testbench
// Drives temperature beats through the valid/stall input channel and keeps a
// cycle-free model of the controller. Every accepted result beat is checked
// field by field against the oldest prediction. The run covers several
// register settings and several idle and stall patterns on both channels.
// ---------------------------------------------------------------------------
module tb_windowed_pid_heater_control;
  import whc_pkg::*;

  // Width of the running window sum.
  localparam int SUM_W = 18;
  // Indexes with no register behind them.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  // Saturation limits of the raw drive.
  localparam longint RAW_MAX = 32767;
  localparam longint RAW_MIN = -32768;
  // Cycle budget for the whole run.
  localparam int unsigned CYCLE_LIMIT = 300000;
  // Idle and stall percentages of the random phases.
  localparam int unsigned SENDER_IDLE_PLAN[4] = '{0, 77, 0, 38};
  localparam int unsigned RECV_STALL_PLAN[4]  = '{0, 0, 77, 38};

  typedef struct {
    logic signed [TEMP_W-1:0] measured;
    logic signed [TEMP_W-1:0] pad;
    bit                       drain;
  } heater_sample_t;

  typedef struct {
    logic [DRIVE_W-1:0]      drive;
    logic signed [RAW_W-1:0] raw_drive;
    logic                    cutoff;
    logic                    clamped;
  } heater_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [TEMP_W-1:0] in_measured_temp = '0;
  logic signed [TEMP_W-1:0] in_pad_temp = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [DRIVE_W-1:0]       out_drive;
  logic signed [RAW_W-1:0]  out_raw_drive;
  logic                     out_cutoff;
  logic                     out_clamped;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  // Model copy of the registers, at their reset values.
  logic signed [TEMP_W-1:0] setpoint = TARGET_TEMP_RST;
  logic signed [TEMP_W-1:0] pad_limit = MAX_PAD_TEMP_RST;
  logic signed [GAIN_W-1:0] p_gain_reg = P_GAIN_RST;
  logic signed [GAIN_W-1:0] i_gain_reg = I_GAIN_RST;
  logic signed [GAIN_W-1:0] d_gain_reg = D_GAIN_RST;
  logic [WLEN_W-1:0]        window_len = WINDOW_LENGTH_RST;

  // Model copy of the error window state.
  logic signed [ERR_W-1:0]  error_ring[WINDOW_DEPTH_DEF] = '{default: '0};
  int unsigned              window_pos = 0;
  logic signed [SUM_W-1:0]  error_sum = '0;
  logic signed [ERR_W-1:0]  prev_error = '0;

  heater_sample_t pending_samples[$];
  heater_result_t predicted_results[$];
  bit             in_beat_taken = 1'b0;
  int unsigned    sender_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    fail_count = 0;
  int unsigned    cycle_count = 0;

  windowed_pid_heater_control dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_measured_temp (in_measured_temp),
    .in_pad_temp      (in_pad_temp),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_drive        (out_drive),
    .out_raw_drive    (out_raw_drive),
    .out_cutoff       (out_cutoff),
    .out_clamped      (out_clamped),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // Advance the window model by one beat and return the result it causes.
  function automatic heater_result_t predict_heater_result(
    input logic signed [TEMP_W-1:0] meas,
    input logic signed [TEMP_W-1:0] pad
  );
    heater_result_t res;
    longint         err;
    longint         deriv;
    longint         acc;
    longint         raw;
    int unsigned    live_len;
    int unsigned    slot;
    err = longint'(setpoint) - longint'(meas);
    deriv = err - longint'(prev_error);
    // A length of zero acts as one, anything above the depth as the depth.
    if (window_len == 0) begin
      live_len = 1;
    end else if (window_len > WINDOW_DEPTH_DEF) begin
      live_len = WINDOW_DEPTH_DEF;
    end else begin
      live_len = window_len;
    end
    // The new error replaces the oldest entry, then the position wraps.
    slot = window_pos % WINDOW_DEPTH_DEF;
    error_sum = SUM_W'(longint'(error_sum) - longint'(error_ring[slot]) + err);
    error_ring[slot] = ERR_W'(err);
    slot++;
    window_pos = (slot >= live_len) ? 0 : slot;
    // Exact products, floor shift, then saturation to 16 bits.
    acc = longint'(p_gain_reg) * err + longint'(i_gain_reg) * longint'(error_sum)
        + longint'(d_gain_reg) * deriv;
    raw = acc >>> FRAC_SHIFT;
    if (raw > RAW_MAX) begin
      raw = RAW_MAX;
    end else if (raw < RAW_MIN) begin
      raw = RAW_MIN;
    end
    prev_error = ERR_W'(err);
    res.raw_drive = RAW_W'(raw);
    res.clamped = (raw < 0) || (raw > longint'(DRIVE_MAX));
    if (raw < 0) begin
      res.drive = '0;
    end else if (raw > longint'(DRIVE_MAX)) begin
      res.drive = DRIVE_MAX;
    end else begin
      res.drive = DRIVE_W'(raw);
    end
    // Pad over-temperature forces the drive off but keeps the clamp flag.
    res.cutoff = pad > pad_limit;
    if (res.cutoff) begin
      res.drive = '0;
    end
    return res;
  endfunction

  // Random register value: mostly moderate, sometimes the extremes.
  function automatic logic [CFG_DATA_W-1:0] random_reg_value(
    input logic [CFG_IDX_W-1:0] idx
  );
    logic [CFG_DATA_W-1:0] val;
    val = CFG_DATA_W'($urandom);
    case (idx)
      REG_TARGET_TEMP, REG_MAX_PAD_TEMP: begin
        case ($urandom_range(7))
          0: val[TEMP_W-1:0] = 13'h0FFF;
          1: val[TEMP_W-1:0] = 13'h1000;
          default: ;
        endcase
      end
      REG_P_GAIN, REG_I_GAIN, REG_D_GAIN: begin
        case ($urandom_range(9))
          0: val = 16'h7FFF;
          1: val = 16'h8000;
          2: val = 16'h0000;
          3: ;
          default: val = CFG_DATA_W'($urandom_range(10240)) - 16'd2048;
        endcase
      end
      REG_WINDOW_LENGTH: begin
        if ($urandom_range(3) != 0) begin
          val[WLEN_W-1:0] = WLEN_W'($urandom_range(WINDOW_DEPTH_DEF, 1));
        end
      end
      default: ;
    endcase
    return val;
  endfunction

  // Write one register and mirror it into the model.
  task automatic write_register(
    input logic [CFG_IDX_W-1:0]  idx,
    input logic [CFG_DATA_W-1:0] data
  );
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TARGET_TEMP:  setpoint   = data[TEMP_W-1:0];
      REG_MAX_PAD_TEMP: pad_limit  = data[TEMP_W-1:0];
      REG_P_GAIN:       p_gain_reg = data;
      REG_I_GAIN:       i_gain_reg = data;
      REG_D_GAIN:       d_gain_reg = data;
      REG_WINDOW_LENGTH: begin
        // A length write also empties the window.
        window_len = data[WLEN_W-1:0];
        foreach (error_ring[k]) error_ring[k] = '0;
        window_pos = 0;
        error_sum = '0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_sample(input int meas, input int pad, input bit drain);
    heater_sample_t s;
    s.measured = TEMP_W'(meas);
    s.pad = TEMP_W'(pad);
    s.drain = drain;
    pending_samples.push_back(s);
  endtask

  // Wait until every queued beat went in and every result came out.
  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Input driver and output stall, updated at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (!in_valid || in_beat_taken) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
            !(pending_samples[0].drain && predicted_results.size() != 0)) begin
          in_valid         <= 1'b1;
          in_measured_temp <= pending_samples[0].measured;
          in_pad_temp      <= pending_samples[0].pad;
          void'(pending_samples.pop_front());
        end else begin
          in_valid         <= 1'b0;
          in_measured_temp <= TEMP_W'($urandom);
          in_pad_temp      <= TEMP_W'($urandom);
        end
      end
    end
  end

  // Monitor: predict on each input beat, check each result beat.
  always @(posedge clk) begin : result_monitor
    heater_result_t want;
    if (!rst_n) begin
      in_beat_taken = 1'b0;
    end else begin
      in_beat_taken = in_valid && !in_stall;
      if (in_beat_taken) begin
        predicted_results.push_back(predict_heater_result(in_measured_temp, in_pad_temp));
      end
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $error("result beat with no prediction waiting");
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          if (out_drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", want.drive, out_drive);
            fail_count++;
          end
          if (out_raw_drive !== want.raw_drive) begin
            $error("raw_drive: expected %0d, got %0d", want.raw_drive, out_raw_drive);
            fail_count++;
          end
          if (out_cutoff !== want.cutoff) begin
            $error("cutoff: expected %0d, got %0d", want.cutoff, out_cutoff);
            fail_count++;
          end
          if (out_clamped !== want.clamped) begin
            $error("clamped: expected %0d, got %0d", want.clamped, out_clamped);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("windowed_pid_heater_control verification failed");
      $finish;
    end
  end

  initial begin
    int meas_v;
    int pad_v;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Defaults: zero error, pad at and above the limit, floor rounding of
    // small negative sums, clamping on both sides.
    queue_sample(592, 672, 1'b0);
    queue_sample(0, 673, 1'b0);
    queue_sample(-4096, -4096, 1'b0);
    queue_sample(4095, 4095, 1'b0);
    queue_sample(600, 0, 1'b0);
    queue_sample(584, 0, 1'b0);
    wait_drained();

    // Largest positive gains and setpoint, full window, lowest pad limit.
    write_register(REG_TARGET_TEMP, 16'h0FFF);
    write_register(REG_MAX_PAD_TEMP, 16'hF000);
    write_register(REG_P_GAIN, 16'h7FFF);
    write_register(REG_I_GAIN, 16'h7FFF);
    write_register(REG_D_GAIN, 16'h7FFF);
    write_register(REG_WINDOW_LENGTH, 16'd16);
    queue_sample(-4096, -4096, 1'b0);
    queue_sample(-4096, -4095, 1'b0);
    queue_sample(4095, -4096, 1'b0);
    queue_sample(4000, 100, 1'b0);
    wait_drained();

    // Most negative gains and setpoint; a zero length acts as one.
    write_register(REG_TARGET_TEMP, 16'h1000);
    write_register(REG_MAX_PAD_TEMP, 16'h0FFF);
    write_register(REG_P_GAIN, 16'h8000);
    write_register(REG_I_GAIN, 16'h8000);
    write_register(REG_D_GAIN, 16'h8000);
    write_register(REG_WINDOW_LENGTH, 16'd0);
    queue_sample(4095, 4095, 1'b0);
    queue_sample(-4096, -4096, 1'b0);
    queue_sample(-4000, 4095, 1'b0);
    queue_sample(0, 0, 1'b0);
    wait_drained();

    // Oversized length acts as the full depth; writes to spare indexes do
    // nothing; integral term alone.
    write_register(REG_WINDOW_LENGTH, 16'hFFFF);
    write_register(REG_SPARE_6, 16'hFFFF);
    write_register(REG_SPARE_7, 16'h1234);
    write_register(REG_TARGET_TEMP, 16'd0);
    write_register(REG_P_GAIN, 16'd0);
    write_register(REG_I_GAIN, 16'h0100);
    write_register(REG_D_GAIN, 16'd0);
    queue_sample(-100, 0, 1'b0);
    queue_sample(-200, 0, 1'b0);
    queue_sample(50, 0, 1'b0);
    queue_sample(-4096, 0, 1'b0);
    queue_sample(4095, 0, 1'b0);
    queue_sample(-1, 0, 1'b0);
    wait_drained();

    // Random phases, each with several register settings.
    foreach (SENDER_IDLE_PLAN[ph]) begin
      sender_idle_pct = SENDER_IDLE_PLAN[ph];
      recv_stall_pct = RECV_STALL_PLAN[ph];
      for (int blk = 0; blk < 3; blk++) begin
        write_register(REG_TARGET_TEMP, random_reg_value(REG_TARGET_TEMP));
        write_register(REG_MAX_PAD_TEMP, random_reg_value(REG_MAX_PAD_TEMP));
        write_register(REG_P_GAIN, random_reg_value(REG_P_GAIN));
        write_register(REG_I_GAIN, random_reg_value(REG_I_GAIN));
        write_register(REG_D_GAIN, random_reg_value(REG_D_GAIN));
        write_register(REG_WINDOW_LENGTH, random_reg_value(REG_WINDOW_LENGTH));
        if ($urandom_range(3) == 0) begin
          write_register(($urandom_range(1) != 0) ? REG_SPARE_6 : REG_SPARE_7,
                         CFG_DATA_W'($urandom));
        end
        // Readings mostly near the setpoint and the pad limit so that the
        // drive lands inside its range and the cutoff edge is hit.
        for (int n = 0; n < 63; n++) begin
          if ($urandom_range(9) < 6) begin
            meas_v = int'(setpoint) + int'($urandom_range(128)) - 64;
          end else begin
            meas_v = int'($urandom);
          end
          if ($urandom_range(3) < 2) begin
            pad_v = int'(pad_limit) + int'($urandom_range(4)) - 2;
          end else begin
            pad_v = int'($urandom);
          end
          queue_sample(meas_v, pad_v, (n == 30) || ($urandom_range(39) == 0));
        end
        wait_drained();
      end
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && predicted_results.size() == 0) begin
      $display("windowed_pid_heater_control verification clean");
    end else begin
      $display("windowed_pid_heater_control verification failed");
    end
    $finish;
  end

endmodule
